// ----- design/twmc_pkg.sv -----
// Package for the two-wire master controller: register map, status codes,
// bus action codes and the state, request and result types.
// No dependencies.
package twmc_pkg;

  localparam logic [2:0] REG_BIT_RATE = 3'd0;
  localparam logic [2:0] REG_STATUS   = 3'd1;
  localparam logic [2:0] REG_OWN_ADDR = 3'd2;
  localparam logic [2:0] REG_DATA     = 3'd3;
  localparam logic [2:0] REG_CONTROL  = 3'd4;

  localparam int unsigned CTL_INT_BIT   = 7;
  localparam int unsigned CTL_START_BIT = 5;
  localparam int unsigned CTL_STOP_BIT  = 4;
  localparam int unsigned CTL_EN_BIT    = 2;

  localparam logic [7:0] ST_START       = 8'h08;
  localparam logic [7:0] ST_RSTART      = 8'h10;
  localparam logic [7:0] ST_ADDR_W_ACK  = 8'h18;
  localparam logic [7:0] ST_ADDR_W_NACK = 8'h20;
  localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
  localparam logic [7:0] ST_DATA_W_NACK = 8'h30;
  localparam logic [7:0] ST_ADDR_R_ACK  = 8'h40;
  localparam logic [7:0] ST_ADDR_R_NACK = 8'h48;
  localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
  localparam logic [7:0] ST_DATA_R_NACK = 8'h58;
  localparam logic [7:0] ST_IDLE        = 8'hf8;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_START     = 3'd1,
    ACT_STOP      = 3'd2,
    ACT_STOPSTART = 3'd3,
    ACT_ADDR      = 3'd4,
    ACT_SEND      = 3'd5,
    ACT_RECV      = 3'd6
  } twmc_action_e;

  typedef struct packed {
    logic [7:0] bit_rate;
    logic [7:0] status;
    logic [7:0] own_address;
    logic [7:0] data;
    logic [7:0] control;
    logic       owns_bus;
    logic       start_pending;
    logic       transmit_mode;
  } twmc_state_t;

  localparam twmc_state_t STATE_RESET = '{
    bit_rate:      8'h00,
    status:        8'hf8,
    own_address:   8'hfe,
    data:          8'hff,
    control:       8'h00,
    owns_bus:      1'b0,
    start_pending: 1'b0,
    transmit_mode: 1'b0
  };

  typedef struct packed {
    logic       operation;
    logic [2:0] reg_select;
    logic [7:0] write_data;
    logic       partner_ack;
    logic [7:0] partner_byte;
  } twmc_item_t;

  typedef struct packed {
    logic [7:0]   read_data;
    twmc_action_e bus_action;
    logic [6:0]   bus_address;
    logic         bus_direction_write;
    logic [7:0]   bus_byte;
    logic         fault;
  } twmc_result_t;

endpackage

// ----- design/twmc_core.sv -----
// Register access and bus operation dispatch for one transaction.
// Pure combinational next-state and result logic; depends on twmc_pkg.
module twmc_core (
  input  twmc_pkg::twmc_state_t  state_i,
  input  twmc_pkg::twmc_item_t   item_i,
  output twmc_pkg::twmc_state_t  state_o,
  output twmc_pkg::twmc_result_t result_o
);
  import twmc_pkg::*;

  logic [7:0] wv;
  logic [7:0] code;
  logic       finish;

  assign wv = item_i.write_data;

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    result_o.bus_action = ACT_NONE;
    code     = ST_IDLE;
    finish   = 1'b0;
    if (!item_i.operation) begin
      case (item_i.reg_select)
        REG_BIT_RATE: result_o.read_data = state_i.bit_rate;
        REG_STATUS:   result_o.read_data = state_i.status;
        REG_OWN_ADDR: result_o.read_data = state_i.own_address;
        REG_DATA:     result_o.read_data = state_i.data;
        REG_CONTROL:  result_o.read_data = state_i.control;
        default:      result_o.read_data = 8'h00;
      endcase
    end else begin
      case (item_i.reg_select)
        REG_BIT_RATE: state_o.bit_rate = wv;
        REG_STATUS:   state_o.status = {state_i.status[7:2], wv[1:0]};
        REG_OWN_ADDR: state_o.own_address = wv;
        REG_DATA:     state_o.data = wv;
        REG_CONTROL: begin
          state_o.control = {(wv[CTL_INT_BIT] ? 1'b0 : state_i.control[CTL_INT_BIT]),
                             wv[6:0]};
          if (!wv[CTL_EN_BIT]) begin
            state_o.owns_bus = 1'b0;
          end else if (wv[CTL_INT_BIT]) begin
            if (wv[CTL_STOP_BIT]) begin
              finish = 1'b1;
              state_o.control[CTL_STOP_BIT] = 1'b0;
              state_o.owns_bus      = wv[CTL_START_BIT];
              state_o.start_pending = wv[CTL_START_BIT];
              code = wv[CTL_START_BIT] ? ST_START : ST_IDLE;
              result_o.bus_action = wv[CTL_START_BIT] ? ACT_STOPSTART : ACT_STOP;
            end else if (wv[CTL_START_BIT]) begin
              finish = 1'b1;
              code = state_i.owns_bus ? ST_RSTART : ST_START;
              state_o.owns_bus      = 1'b1;
              state_o.start_pending = 1'b1;
              result_o.bus_action   = ACT_START;
            end else if (!state_i.owns_bus) begin
              result_o.fault = 1'b1;
            end else if (state_i.start_pending) begin
              finish = 1'b1;
              state_o.transmit_mode = ~state_i.data[0];
              state_o.start_pending = 1'b0;
              result_o.bus_address  = state_i.data[7:1];
              result_o.bus_direction_write = ~state_i.data[0];
              result_o.bus_action   = ACT_ADDR;
              if (!state_i.data[0]) begin
                code = item_i.partner_ack ? ST_ADDR_W_ACK : ST_ADDR_W_NACK;
              end else begin
                code = item_i.partner_ack ? ST_ADDR_R_ACK : ST_ADDR_R_NACK;
              end
            end else if (state_i.transmit_mode) begin
              finish = 1'b1;
              result_o.bus_byte = state_i.data;
              result_o.bus_direction_write = 1'b1;
              result_o.bus_action = ACT_SEND;
              code = item_i.partner_ack ? ST_DATA_W_ACK : ST_DATA_W_NACK;
            end else begin
              finish = 1'b1;
              state_o.data = item_i.partner_byte;
              result_o.bus_action = ACT_RECV;
              code = item_i.partner_ack ? ST_DATA_R_ACK : ST_DATA_R_NACK;
            end
          end
        end
        default: ;
      endcase
    end
    if (finish) begin
      state_o.control[CTL_INT_BIT] = 1'b1;
      state_o.status = {code[7:3], 1'b0, state_i.status[1:0]};
    end
  end

endmodule

// ----- design/two_wire_master_controller.sv -----
// Two-wire master controller top level: register state, result register
// and skid stage around twmc_core; depends on twmc_pkg and twmc_core.
//
//  channel   direction  tdata fields (lowest bit up)
//  s_*       in         operation, reg_select, write_data, partner_ack, partner_byte
//  m_*       out        read_data, bus_action, bus_address, bus_direction_write,
//                       bus_byte, fault
//
// One transaction per cycle while s_tready_o is high; results are registered.
// The register file updates at acceptance; the result register and one skid
// stage hold results while m_tready_i is low, so s_tready_o drops only when
// both are full. Reset restores the register reset values and empties both.
module two_wire_master_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  // operation, reg_select[2:0], write_data[7:0], partner_ack, partner_byte[7:0]
  input  logic [23:0] s_tdata_i,
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  // read_data[7:0], bus_action[2:0], bus_address[6:0], bus_direction_write,
  // bus_byte[7:0], fault
  output logic [31:0] m_tdata_o
);
  import twmc_pkg::*;

  twmc_state_t  state_q, state_d;
  twmc_item_t   item;
  twmc_result_t result;
  twmc_result_t out_q, out_d, skid_q, skid_d;
  logic         out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic         accept;

  assign item.operation    = s_tdata_i[0];
  assign item.reg_select   = s_tdata_i[3:1];
  assign item.write_data   = s_tdata_i[11:4];
  assign item.partner_ack  = s_tdata_i[12];
  assign item.partner_byte = s_tdata_i[20:13];

  twmc_core u_core (
    .state_i  (state_q),
    .item_i   (item),
    .state_o  (state_d),
    .result_o (result)
  );

  assign s_tready_o = ~skid_valid_q;
  assign accept     = s_tvalid_i & s_tready_o;

  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (!out_valid_q || m_tready_i) begin
      out_valid_d  = skid_valid_q | accept;
      out_d        = skid_valid_q ? skid_q : result;
      skid_valid_d = 1'b0;
    end else if (accept) begin
      skid_valid_d = 1'b1;
      skid_d       = result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= STATE_RESET;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        state_q <= state_d;
      end
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {4'b0000, out_q.fault, out_q.bus_byte, out_q.bus_direction_write,
                       out_q.bus_address, out_q.bus_action, out_q.read_data};

endmodule

// ----- design/twmc_checker.sv -----
// Port-level checker for the two-wire master controller, with its bind.
// Depends on twmc_pkg and two_wire_master_controller.
module twmc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_tvalid_o,
  input logic        m_tready_i,
  input logic [31:0] m_tdata_o
);
  import twmc_pkg::*;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o))
    else $error("result changed while stalled");

  a_fault_no_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tdata_o[27] |-> m_tdata_o[10:8] == ACT_NONE)
    else $error("fault with a bus action");

  a_addr_only_on_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tdata_o[10:8] != ACT_ADDR |-> m_tdata_o[17:11] == 7'd0)
    else $error("address outside an address action");

  a_byte_only_on_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tdata_o[10:8] != ACT_SEND |-> m_tdata_o[26:19] == 8'd0)
    else $error("bus byte outside a send action");

  a_dir_only_on_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tdata_o[18] |-> m_tdata_o[10:8] == ACT_ADDR ||
                                   m_tdata_o[10:8] == ACT_SEND)
    else $error("write direction outside address or send");

endmodule

bind two_wire_master_controller twmc_checker u_twmc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o)
);

// ----- verif/tb_two_wire_master_controller.sv -----
// Self-checking testbench for two_wire_master_controller: directed register and bus
// operation table, then random start/address/data/stop sequences mixed with noise.
// Depends on twmc_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_two_wire_master_controller;
  import twmc_pkg::*;

  localparam logic       OP_READ      = 1'b0;
  localparam logic       OP_WRITE     = 1'b1;
  localparam logic [2:0] REG_SPARE    = 3'd5;
  localparam logic [2:0] REG_UNMAPPED = 3'd7;
  localparam int         DIR_ROWS     = 25;
  localparam int         RAND_ITEMS   = 500;

  typedef struct packed {
    logic         has_exp;
    twmc_item_t   acc;
    twmc_result_t want;
  } access_row_t;

  localparam twmc_result_t NO_CHECK = '0;

  localparam access_row_t DIR_TAB [DIR_ROWS] = '{
    '{1'b1, '{OP_READ, REG_BIT_RATE, 8'h00, 1'b0, 8'h00},
      '{8'h00, ACT_NONE, 7'h00, 1'b0, 8'h00, 1'b0}},
    '{1'b1, '{OP_READ, REG_STATUS, 8'hff, 1'b1, 8'hff},
      '{8'hf8, ACT_NONE, 7'h00, 1'b0, 8'h00, 1'b0}},
    '{1'b1, '{OP_READ, REG_OWN_ADDR, 8'h00, 1'b0, 8'h00},
      '{8'hfe, ACT_NONE, 7'h00, 1'b0, 8'h00, 1'b0}},
    '{1'b1, '{OP_READ, REG_DATA, 8'h00, 1'b0, 8'h00},
      '{8'hff, ACT_NONE, 7'h00, 1'b0, 8'h00, 1'b0}},
    '{1'b1, '{OP_READ, REG_CONTROL, 8'h00, 1'b0, 8'h00},
      '{8'h00, ACT_NONE, 7'h00, 1'b0, 8'h00, 1'b0}},
    '{1'b1, '{OP_READ, REG_UNMAPPED, 8'h00, 1'b0, 8'h00},
      '{8'h00, ACT_NONE, 7'h00, 1'b0, 8'h00, 1'b0}},
    '{1'b1, '{OP_WRITE, REG_CONTROL, 8'h85, 1'b1, 8'h00},
      '{8'h00, ACT_NONE, 7'h00, 1'b0, 8'h00, 1'b1}},
    '{1'b0, '{OP_WRITE, REG_BIT_RATE, 8'hff, 1'b0, 8'h00}, NO_CHECK},
    '{1'b0, '{OP_WRITE, REG_STATUS, 8'hff, 1'b0, 8'h00}, NO_CHECK},
    '{1'b1, '{OP_READ, REG_STATUS, 8'h00, 1'b0, 8'h00},
      '{8'hfb, ACT_NONE, 7'h00, 1'b0, 8'h00, 1'b0}},
    '{1'b0, '{OP_WRITE, REG_OWN_ADDR, 8'h00, 1'b0, 8'h00}, NO_CHECK},
    '{1'b0, '{OP_WRITE, REG_SPARE, 8'hff, 1'b0, 8'h00}, NO_CHECK},
    '{1'b0, '{OP_WRITE, REG_CONTROL, 8'he5, 1'b1, 8'h00}, NO_CHECK},
    '{1'b0, '{OP_WRITE, REG_DATA, 8'ha0, 1'b0, 8'h00}, NO_CHECK},
    '{1'b0, '{OP_WRITE, REG_CONTROL, 8'hc4, 1'b1, 8'h00}, NO_CHECK},
    '{1'b0, '{OP_WRITE, REG_DATA, 8'hff, 1'b0, 8'h00}, NO_CHECK},
    '{1'b0, '{OP_WRITE, REG_CONTROL, 8'hc4, 1'b0, 8'h00}, NO_CHECK},
    '{1'b0, '{OP_WRITE, REG_CONTROL, 8'ha4, 1'b1, 8'h00}, NO_CHECK},
    '{1'b0, '{OP_WRITE, REG_DATA, 8'ha1, 1'b0, 8'h00}, NO_CHECK},
    '{1'b0, '{OP_WRITE, REG_CONTROL, 8'hc4, 1'b1, 8'h00}, NO_CHECK},
    '{1'b0, '{OP_WRITE, REG_CONTROL, 8'h84, 1'b0, 8'hff}, NO_CHECK},
    '{1'b0, '{OP_WRITE, REG_CONTROL, 8'h44, 1'b1, 8'h00}, NO_CHECK},
    '{1'b0, '{OP_WRITE, REG_CONTROL, 8'hb4, 1'b0, 8'h00}, NO_CHECK},
    '{1'b0, '{OP_WRITE, REG_CONTROL, 8'h94, 1'b1, 8'h00}, NO_CHECK},
    '{1'b0, '{OP_WRITE, REG_CONTROL, 8'h00, 1'b0, 8'h00}, NO_CHECK}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid_i;
  logic        s_tready_o;
  logic [23:0] s_tdata_i;
  logic        m_tvalid_o;
  logic        m_tready_i;
  logic [31:0] m_tdata_o;

  two_wire_master_controller uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

  logic [7:0] bit_rate_q;
  logic [7:0] status_q;
  logic [7:0] own_addr_q;
  logic [7:0] data_q;
  logic [7:0] control_q;
  logic       owns_bus_q;
  logic       addr_pending_q;
  logic       transmit_q;

  access_row_t  access_q[$];
  twmc_result_t bus_result_q[$];
  int           mismatch_cnt;
  int           result_cnt;
  int           action_cnt [8];
  int           fault_cnt;
  int           stall_left;
  logic         steady;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [23:0] pack_access(twmc_item_t a);
    return {3'b000, a.partner_byte, a.partner_ack, a.write_data, a.reg_select, a.operation};
  endfunction

  function automatic twmc_result_t unpack_result(logic [31:0] d);
    twmc_result_t r;
    r.read_data           = d[7:0];
    r.bus_action          = twmc_action_e'(d[10:8]);
    r.bus_address         = d[17:11];
    r.bus_direction_write = d[18];
    r.bus_byte            = d[26:19];
    r.fault               = d[27];
    return r;
  endfunction

  function automatic void post_status(logic [7:0] code);
    control_q[CTL_INT_BIT] = 1'b1;
    status_q = {code[7:3], 1'b0, status_q[1:0]};
  endfunction

  function automatic void take_bus();
    post_status(owns_bus_q ? ST_RSTART : ST_START);
    owns_bus_q     = 1'b1;
    addr_pending_q = 1'b1;
  endfunction

  function automatic twmc_result_t predict_access(twmc_item_t a);
    twmc_result_t r;
    logic [7:0]   wv;
    logic         wr;
    r  = '0;
    wv = a.write_data;
    if (a.operation == OP_READ) begin
      case (a.reg_select)
        REG_BIT_RATE: r.read_data = bit_rate_q;
        REG_STATUS:   r.read_data = status_q;
        REG_OWN_ADDR: r.read_data = own_addr_q;
        REG_DATA:     r.read_data = data_q;
        REG_CONTROL:  r.read_data = control_q;
        default:      r.read_data = 8'h00;
      endcase
    end else begin
      case (a.reg_select)
        REG_BIT_RATE: bit_rate_q = wv;
        REG_STATUS:   status_q = {status_q[7:2], wv[1:0]};
        REG_OWN_ADDR: own_addr_q = wv;
        REG_DATA:     data_q = wv;
        REG_CONTROL: begin
          control_q = {wv[CTL_INT_BIT] ? 1'b0 : control_q[CTL_INT_BIT], wv[6:0]};
          if (!wv[CTL_EN_BIT]) begin
            owns_bus_q = 1'b0;
          end else if (wv[CTL_INT_BIT]) begin
            if (wv[CTL_STOP_BIT]) begin
              post_status(ST_IDLE);
              control_q[CTL_STOP_BIT] = 1'b0;
              owns_bus_q     = 1'b0;
              addr_pending_q = 1'b0;
              r.bus_action   = ACT_STOP;
              if (wv[CTL_START_BIT]) begin
                take_bus();
                r.bus_action = ACT_STOPSTART;
              end
            end else if (wv[CTL_START_BIT]) begin
              take_bus();
              r.bus_action = ACT_START;
            end else if (!owns_bus_q) begin
              r.fault = 1'b1;
            end else if (addr_pending_q) begin
              wr                    = ~data_q[0];
              transmit_q            = wr;
              r.bus_address         = data_q[7:1];
              r.bus_direction_write = wr;
              r.bus_action          = ACT_ADDR;
              if (wr) begin
                post_status(a.partner_ack ? ST_ADDR_W_ACK : ST_ADDR_W_NACK);
              end else begin
                post_status(a.partner_ack ? ST_ADDR_R_ACK : ST_ADDR_R_NACK);
              end
              addr_pending_q = 1'b0;
            end else if (transmit_q) begin
              r.bus_byte            = data_q;
              r.bus_direction_write = 1'b1;
              r.bus_action          = ACT_SEND;
              post_status(a.partner_ack ? ST_DATA_W_ACK : ST_DATA_W_NACK);
            end else begin
              data_q       = a.partner_byte;
              r.bus_action = ACT_RECV;
              post_status(a.partner_ack ? ST_DATA_R_ACK : ST_DATA_R_NACK);
            end
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(string what);
    mismatch_cnt++;
    if (mismatch_cnt <= 40) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  task automatic check_result(twmc_result_t got, twmc_result_t want);
    if (got.read_data !== want.read_data)
      report_mismatch($sformatf("read_data %02h, want %02h", got.read_data, want.read_data));
    if (got.bus_action !== want.bus_action)
      report_mismatch($sformatf("bus_action %0d, want %0d", got.bus_action, want.bus_action));
    if (got.bus_address !== want.bus_address)
      report_mismatch($sformatf("bus_address %02h, want %02h",
                                got.bus_address, want.bus_address));
    if (got.bus_direction_write !== want.bus_direction_write)
      report_mismatch($sformatf("bus_direction_write %0b, want %0b",
                                got.bus_direction_write, want.bus_direction_write));
    if (got.bus_byte !== want.bus_byte)
      report_mismatch($sformatf("bus_byte %02h, want %02h", got.bus_byte, want.bus_byte));
    if (got.fault !== want.fault)
      report_mismatch($sformatf("fault %0b, want %0b", got.fault, want.fault));
  endtask

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void push_access(logic op, logic [2:0] sel, logic [7:0] wv,
                                      logic ack, logic [7:0] pb);
    access_row_t row;
    row.has_exp = 1'b0;
    row.acc     = '{op, sel, wv, ack, pb};
    row.want    = NO_CHECK;
    access_q.push_back(row);
  endfunction

  // interrupt flag and enable set; bits 6, 3, 1 and 0 random
  function automatic logic [7:0] ctl_cmd(logic start, logic stop);
    logic [7:0] r;
    r = 8'($urandom);
    r[CTL_INT_BIT]   = 1'b1;
    r[CTL_START_BIT] = start;
    r[CTL_STOP_BIT]  = stop;
    r[CTL_EN_BIT]    = 1'b1;
    return r;
  endfunction

  function automatic void push_dispatch();
    push_access(OP_WRITE, REG_CONTROL, ctl_cmd(1'b0, 1'b0),
                logic'($urandom_range(0, 3) != 0), 8'($urandom));
  endfunction

  function automatic void build_random_accesses();
    logic [7:0] sla;
    int         n;
    int         c;
    while (access_q.size() < DIR_ROWS + RAND_ITEMS) begin
      if ($urandom_range(0, 99) < 70) begin
        push_access(OP_WRITE, REG_CONTROL, ctl_cmd(1'b1, 1'b0), 1'($urandom), 8'($urandom));
        sla = 8'($urandom);
        push_access(OP_WRITE, REG_DATA, sla, 1'($urandom), 8'($urandom));
        push_dispatch();
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++) begin
          c = $urandom_range(0, 9);
          if (c == 0) begin
            push_access(OP_WRITE, REG_CONTROL, ctl_cmd(1'b1, 1'b0), 1'($urandom),
                        8'($urandom));
            sla = 8'($urandom);
            push_access(OP_WRITE, REG_DATA, sla, 1'($urandom), 8'($urandom));
            push_dispatch();
          end else if (c == 1) begin
            push_access(OP_READ, 3'($urandom_range(0, 4)), 8'($urandom), 1'($urandom),
                        8'($urandom));
          end
          if (!sla[0] && $urandom_range(0, 3) != 0) begin
            push_access(OP_WRITE, REG_DATA, 8'($urandom), 1'($urandom), 8'($urandom));
          end
          push_dispatch();
        end
        push_access(OP_WRITE, REG_CONTROL, ctl_cmd(logic'($urandom_range(0, 4) == 0), 1'b1),
                    1'($urandom), 8'($urandom));
      end else begin
        push_access(1'($urandom), 3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
                    8'($urandom));
      end
    end
  endfunction

  // result side: random backpressure, checked against the oldest expected result
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_tready_i <= 1'b0;
      stall_left <= 0;
    end else begin
      if (m_tvalid_o && m_tready_i) begin
        result_cnt++;
        if (bus_result_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result %08h", m_tdata_o));
        end else begin
          check_result(unpack_result(m_tdata_o), bus_result_q.pop_front());
        end
      end
      if (stall_left > 0) begin
        m_tready_i <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        m_tready_i <= 1'b1;
        if ($urandom_range(0, 3) == 0) begin
          stall_left <= idle_len();
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb_two_wire_master_controller: FAIL");
    $finish;
  end

  initial begin
    access_row_t  row;
    twmc_result_t pred;
    int           gap;
    int           sent;
    rst_ni       = 1'b0;
    s_tvalid_i   = 1'b0;
    s_tdata_i    = '0;
    m_tready_i   = 1'b0;
    mismatch_cnt = 0;
    result_cnt   = 0;
    fault_cnt    = 0;
    stall_left   = 0;
    steady       = 1'b0;
    sent         = 0;
    foreach (action_cnt[k]) action_cnt[k] = 0;
    {bit_rate_q, status_q, own_addr_q, data_q, control_q} =
      {STATE_RESET.bit_rate, STATE_RESET.status, STATE_RESET.own_address,
       STATE_RESET.data, STATE_RESET.control};
    owns_bus_q     = STATE_RESET.owns_bus;
    addr_pending_q = STATE_RESET.start_pending;
    transmit_q     = STATE_RESET.transmit_mode;

    for (int k = 0; k < DIR_ROWS; k++) access_q.push_back(DIR_TAB[k]);
    build_random_accesses();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    while (access_q.size() > 0) begin
      row = access_q.pop_front();
      if (sent % 50 == 0) steady = ($urandom_range(0, 3) == 0);
      gap = idle_len();
      if (gap > 0) begin
        s_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      s_tvalid_i <= 1'b1;
      s_tdata_i  <= pack_access(row.acc);
      @(posedge clk_i);
      while (!s_tready_o) @(posedge clk_i);
      pred = predict_access(row.acc);
      action_cnt[pred.bus_action]++;
      if (pred.fault) fault_cnt++;
      bus_result_q.push_back(row.has_exp ? row.want : pred);
      sent++;
    end
    s_tvalid_i <= 1'b0;

    while (bus_result_q.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("covered %0d accesses, %0d results checked, %0d mismatches", sent, result_cnt,
             mismatch_cnt);
    $display("bus ops: start %0d stop %0d stop+start %0d addr %0d send %0d recv %0d fault %0d",
             action_cnt[ACT_START], action_cnt[ACT_STOP], action_cnt[ACT_STOPSTART],
             action_cnt[ACT_ADDR], action_cnt[ACT_SEND], action_cnt[ACT_RECV], fault_cnt);
    if (mismatch_cnt == 0) begin
      $display("tb_two_wire_master_controller: PASS");
    end else begin
      $display("tb_two_wire_master_controller: FAIL");
    end
    $finish;
  end

endmodule
